// ===== sv/pdu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdu_pkg: shared types and constants of the point distance unit
// Fixed-point widths, metric codes, exp constants and the small reciprocal
// table used by the Horner step.
// ----------------------------------------------------------------------------
package pdu_pkg;

	localparam int FEAT_W   = 16;
	localparam int SUM_W    = 40;
	localparam int OUT_W    = 20;
	localparam int INV_W    = 24;
	localparam int METRIC_W = 2;

	localparam logic [METRIC_W-1:0] METRIC_EUCLID = 2'd0;
	localparam logic [METRIC_W-1:0] METRIC_KERNEL = 2'd1;

	localparam logic [0:0] REG_METRIC = 1'b0;
	localparam logic [0:0] REG_INV    = 1'b1;

	localparam logic [32:0] LOG2E_Q16 = 33'd94548;
	localparam logic [32:0] LN2_Q30   = 33'd744261118;
	localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
	localparam logic [21:0] X_LIMIT   = 22'h20_0000;
	localparam logic [17:0] KERN_TWO  = 18'd131072;

	typedef struct packed {
		logic [METRIC_W-1:0] metric;
		logic [INV_W-1:0]    inv_sigma_sq;
	} cfg_t;

	// floor(2^32 / k) for k = 1..8; underestimates the quotient by at most one
	function automatic logic [32:0] recip(input logic [3:0] k);
		logic [32:0] r;
		case (k)
			4'd1: r = 33'h1_0000_0000;
			4'd2: r = 33'h0_8000_0000;
			4'd3: r = 33'd1431655765;
			4'd4: r = 33'h0_4000_0000;
			4'd5: r = 33'd858993459;
			4'd6: r = 33'd715827882;
			4'd7: r = 33'd613566756;
			4'd8: r = 33'h0_2000_0000;
			default: r = 33'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/pdu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdu_front: squared-difference accumulator
// Squares each feature difference, adds it into a saturating sum and pushes
// the sum to the queue on the last feature of a point pair.
// ----------------------------------------------------------------------------
module pdu_front import pdu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_valid,
	output logic              s_ready,
	input  logic [FEAT_W-1:0] feature_a,
	input  logic [FEAT_W-1:0] feature_b,
	input  logic              last,
	input  logic              q_full,
	output logic              q_push,
	output logic [SUM_W-1:0]  q_data
);

	logic [FEAT_W:0]    diff;
	logic [FEAT_W-1:0]  mag;
	logic               valid_s1;
	logic               last_s1;
	logic [31:0]        sq_s1;
	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W:0]     sum_wide;
	logic [SUM_W-1:0]   sum_sat;
	logic               adv;

	// magnitude of the signed difference
	always_comb begin
		diff = {feature_a[FEAT_W-1], feature_a} - {feature_b[FEAT_W-1], feature_b};
		if (diff[FEAT_W])
			mag = FEAT_W'(-diff);
		else
			mag = diff[FEAT_W-1:0];
	end

	// saturating accumulate
	assign sum_wide = {1'b0, sum_q} + {{(SUM_W-31){1'b0}}, sq_s1};
	assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

	assign adv     = valid_s1 && (!last_s1 || !q_full);
	assign s_ready = !valid_s1 || adv;
	assign q_push  = adv && last_s1;
	assign q_data  = sum_sat;

	// square stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_ready) begin
			valid_s1 <= s_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_ready && s_valid) begin
			sq_s1   <= mag * mag;
			last_s1 <= last;
		end
	end

	// accumulator, cleared after each pushed sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (adv) begin
			sum_q <= last_s1 ? '0 : sum_sat;
		end
	end

endmodule

// ===== sv/pdu_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdu_queue: two-entry queue of finished sums
// Decouples the accumulator from the root and exponential sequencer.
// ----------------------------------------------------------------------------
module pdu_queue import pdu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [SUM_W-1:0] wdata,
	input  logic             pop,
	output logic [SUM_W-1:0] rdata,
	output logic             empty,
	output logic             full
);

	logic [SUM_W-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== sv/pdu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdu_back: distance sequencer
// Turns a queued sum into a distance: bit-serial square root, or the kernel
// distance through one shared registered multiplier, then holds the result.
// ----------------------------------------------------------------------------
module pdu_back import pdu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             q_empty,
	input  logic [SUM_W-1:0] q_data,
	output logic             q_pop,
	output logic             m_valid,
	input  logic             m_ready,
	output logic [OUT_W-1:0] distance_value
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SQRT = 4'd1;
	localparam logic [3:0] ST_KHI  = 4'd2;
	localparam logic [3:0] ST_KLO  = 4'd3;
	localparam logic [3:0] ST_KX   = 4'd4;
	localparam logic [3:0] ST_KY   = 4'd5;
	localparam logic [3:0] ST_KF   = 4'd6;
	localparam logic [3:0] ST_KT   = 4'd7;
	localparam logic [3:0] ST_HA   = 4'd8;
	localparam logic [3:0] ST_HB   = 4'd9;
	localparam logic [3:0] ST_HC   = 4'd10;
	localparam logic [3:0] ST_EXP  = 4'd11;
	localparam logic [3:0] ST_FIN  = 4'd12;

	logic [3:0]       state_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W:0]   root_q;
	logic [SUM_W:0]   bit_q;
	logic [43:0]      hi_q;
	logic [21:0]      x_q;
	logic [5:0]       n_q;
	logic [29:0]      t_q;
	logic [30:0]      p_q;
	logic [30:0]      qv_q;
	logic [3:0]       k_q;
	logic [OUT_W-1:0] res_q;
	logic [64:0]      mul_q;
	logic [31:0]      op_a;
	logic [32:0]      op_b;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_q;

	// square root step
	logic [SUM_W:0]   trial;
	logic             take;
	// kernel scaling
	logic [44:0]      prod;
	logic [44:0]      xs;
	// Horner division correction
	logic [30:0]      est;
	logic [34:0]      estk;
	logic [34:0]      rem;
	logic [30:0]      quo;
	// final exponential
	logic [30:0]      e_val;
	logic [31:0]      e_rnd;
	logic [18:0]      term;
	logic [17:0]      term_c;

	assign trial = root_q + bit_q;
	assign take  = {1'b0, sum_q} >= trial;

	assign prod = {hi_q[24:0], 20'd0} + {1'b0, mul_q[43:0]};
	assign xs   = {16'd0, prod[44:16]};

	assign est  = mul_q[62:32];
	assign estk = {4'd0, est} * {31'd0, k_q};
	assign rem  = {4'd0, qv_q} - estk;
	assign quo  = (rem >= {31'd0, k_q}) ? est + 31'd1 : est;

	always_comb begin
		e_val  = (n_q >= 6'd30) ? 31'd0 : (p_q >> n_q);
		e_rnd  = {1'b0, e_val} + 32'd4096;
		term   = e_rnd[31:13];
		term_c = (term > {1'b0, KERN_TWO}) ? KERN_TWO : term[17:0];
	end

	// shared multiplier operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			ST_KHI: begin
				op_a = {12'd0, sum_q[39:20]};
				op_b = {9'd0, cfg.inv_sigma_sq};
			end
			ST_KLO: begin
				op_a = {12'd0, sum_q[19:0]};
				op_b = {9'd0, cfg.inv_sigma_sq};
			end
			ST_KY: begin
				op_a = {10'd0, x_q};
				op_b = LOG2E_Q16;
			end
			ST_KF: begin
				op_a = {16'd0, mul_q[31:16]};
				op_b = LN2_Q30;
			end
			ST_HA: begin
				op_a = {2'd0, t_q};
				op_b = {2'd0, p_q};
			end
			ST_HB: begin
				op_a = {1'b0, mul_q[60:30]};
				op_b = recip(k_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= op_a * op_b;
	end

	assign q_pop          = (state_q == ST_IDLE) && !q_empty;
	assign m_valid        = out_valid_q;
	assign distance_value = out_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// output register: load on finish, clear once taken
			if (state_q == ST_FIN && (!out_valid_q || m_ready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						if (cfg.metric == METRIC_EUCLID)
							state_q <= ST_SQRT;
						else if (cfg.metric == METRIC_KERNEL)
							state_q <= ST_KHI;
						else
							state_q <= ST_FIN;
					end
				end
				ST_SQRT: begin
					if (bit_q[1:0] != 2'd0)
						state_q <= ST_FIN;
				end
				ST_KHI: state_q <= ST_KLO;
				ST_KLO: state_q <= ST_KX;
				ST_KX: begin
					if (hi_q >= 44'h2_0000 || xs >= {23'd0, X_LIMIT})
						state_q <= ST_EXP;
					else
						state_q <= ST_KY;
				end
				ST_KY: state_q <= ST_KF;
				ST_KF: state_q <= ST_KT;
				ST_KT: state_q <= ST_HA;
				ST_HA: state_q <= ST_HB;
				ST_HB: state_q <= ST_HC;
				ST_HC: state_q <= (k_q == 4'd1) ? ST_EXP : ST_HA;
				ST_EXP: state_q <= ST_FIN;
				ST_FIN: begin
					if (!out_valid_q || m_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sum_q  <= q_data;
				root_q <= '0;
				bit_q  <= {1'b1, {SUM_W{1'b0}}};
				res_q  <= '0;
			end
			ST_SQRT: begin
				if (take) begin
					sum_q  <= sum_q - trial[SUM_W-1:0];
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[1:0] != 2'd0)
					res_q <= take ? OUT_W'((root_q >> 1) + bit_q) : OUT_W'(root_q >> 1);
			end
			ST_KLO: hi_q <= mul_q[43:0];
			ST_KX: begin
				x_q <= xs[21:0];
				n_q <= '0;
				p_q <= '0;
			end
			ST_KF: n_q <= mul_q[37:32];
			ST_KT: begin
				t_q <= mul_q[45:16];
				p_q <= Q30_ONE;
				k_q <= 4'd8;
			end
			ST_HB: qv_q <= mul_q[60:30];
			ST_HC: begin
				p_q <= Q30_ONE - quo;
				k_q <= k_q - 4'd1;
			end
			ST_EXP: res_q <= OUT_W'(KERN_TWO - term_c);
			ST_FIN: begin
				if (!out_valid_q || m_ready)
					out_q <= res_q;
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/point_distance_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_distance_unit_core: streaming point distance
// Accumulates squared feature differences and gives a Euclidean or Gaussian
// kernel distance per point pair.
//
//   channel | tdata fields (low bit up)             | tlast
//   s       | feature_a[15:0], feature_b[31:16]      | last feature of a pair
//   m       | distance_value[19:0], zero pad to 24   | -
//   cfg     | cfg_index 0 metric, 1 inv_sigma_sq     | -
//
// The accumulator takes one transaction per cycle unless a finished sum meets
// a full queue. The sequencer computes the root one result bit per cycle and
// the kernel through the shared multiplier, 8 Horner terms each through the
// states HA, HB and HC; a two-entry queue lets accumulation run meanwhile.
// Reset clears the accumulator and sets metric 0, inv_sigma_sq 1.0.
// ----------------------------------------------------------------------------
module point_distance_unit_core import pdu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // feature_a, feature_b
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // distance_value, zero pad
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	cfg_t             cfg_q;
	logic             q_full;
	logic             q_empty;
	logic             q_push;
	logic             q_pop;
	logic [SUM_W-1:0] q_wdata;
	logic [SUM_W-1:0] q_rdata;
	logic [OUT_W-1:0] dist_value;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.metric       <= METRIC_EUCLID;
			cfg_q.inv_sigma_sq <= 24'h01_0000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_METRIC: cfg_q.metric       <= cfg_data[METRIC_W-1:0];
				REG_INV:    cfg_q.inv_sigma_sq <= cfg_data;
				default: ;
			endcase
		end
	end

	pdu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (s_tvalid),
		.s_ready   (s_tready),
		.feature_a (s_tdata[15:0]),
		.feature_b (s_tdata[31:16]),
		.last      (s_tlast),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	pdu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.full   (q_full)
	);

	pdu_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_empty        (q_empty),
		.q_data         (q_rdata),
		.q_pop          (q_pop),
		.m_valid        (m_tvalid),
		.m_ready        (m_tready),
		.distance_value (dist_value)
	);

	assign m_tdata = {4'd0, dist_value};

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for point_distance_unit_core
// Streams feature pairs through the slave port with random gaps. A local
// model of the squared-sum accumulator, integer root and fixed-point
// exponential predicts each distance. The checker compares every master
// transaction with the oldest prediction. Configuration changes only while
// the unit is idle.
// ----------------------------------------------------------------------------
module testbench;
	import pdu_pkg::*;

	localparam longint unsigned SUM_MAX  = 64'hFF_FFFF_FFFF;
	localparam longint unsigned OUT_MAX  = 64'hF_FFFF;
	localparam longint unsigned ONE_Q30  = 64'h4000_0000;
	localparam longint unsigned LOG2E    = 64'd94548;
	localparam longint unsigned LN2      = 64'd744261118;
	localparam longint unsigned XSAT     = 64'h20_0000;
	localparam longint unsigned TWO_Q16  = 64'd131072;
	localparam int              SETTLE   = 80;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;    // feature_a[15:0], feature_b[31:16]
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;    // distance_value[19:0], zero pad
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [23:0] cfg_data;

	// model state
	logic [METRIC_W-1:0] cur_metric;
	logic [INV_W-1:0]    cur_inv;
	longint unsigned     acc_sum;
	logic [23:0]         dist_q[$];

	int  n_errors;
	int  n_items;
	int  n_dists;
	int  n_kernel;
	int  n_sat;
	bit  calm;

	point_distance_unit_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#8ms;
		$display("%0t: timeout, %0d distances still pending", $time, dist_q.size());
		$display("** point_distance_unit_core: FAILED **");
		$finish;
	end

	function automatic longint unsigned int_root(input longint unsigned v);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 40;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// 2 - 2*exp(-sum*inv) in Q2.16
	function automatic longint unsigned kernel_dist(input longint unsigned sum,
			input longint unsigned inv);
		longint unsigned hi, x, y, n, f, t, p, e, term;
		hi = (sum >> 20) * inv;
		if (hi >= (64'd1 << 17)) begin
			x = XSAT;
		end else begin
			x = ((hi << 20) + (sum & 64'hF_FFFF) * inv) >> 16;
			if (x > XSAT)
				x = XSAT;
		end
		if (x >= XSAT) begin
			e = 0;
		end else begin
			y = (x * LOG2E) >> 16;
			n = y >> 16;
			f = y & 64'hFFFF;
			t = (f * LN2) >> 16;
			p = ONE_Q30;
			for (int k = 8; k >= 1; k--)
				p = ONE_Q30 - (((t * p) >> 30) / k);
			e = (n >= 30) ? 0 : (p >> n);
		end
		term = (e + 64'd4096) >> 13;
		if (term > TWO_Q16)
			term = TWO_Q16;
		return TWO_Q16 - term;
	endfunction

	// fold one accepted pair into the model; queue a distance on last
	function automatic void accumulate(input logic [15:0] fa, input logic [15:0] fb,
			input logic lst);
		longint signed   d;
		longint unsigned mag, sq, r;
		d = longint'($signed(fa)) - longint'($signed(fb));
		mag = (d < 0) ? longint'(-d) : d;
		sq = mag * mag;
		if (sq >= SUM_MAX - acc_sum) begin
			acc_sum = SUM_MAX;
			n_sat++;
		end else begin
			acc_sum = acc_sum + sq;
		end
		n_items++;
		if (lst) begin
			if (cur_metric == METRIC_EUCLID)
				r = int_root(acc_sum);
			else if (cur_metric == METRIC_KERNEL) begin
				r = kernel_dist(acc_sum, cur_inv);
				n_kernel++;
			end else
				r = 0;
			if (r > OUT_MAX)
				r = OUT_MAX;
			dist_q.push_back({4'd0, r[19:0]});
			acc_sum = 0;
		end
	endfunction

	// output checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (dist_q.size() == 0) begin
				$display("%0t: unexpected distance, expected none, actual %0d",
					$time, m_tdata);
				n_errors++;
			end else begin
				if (m_tdata !== dist_q[0]) begin
					$display("%0t: distance mismatch, expected %0d, actual %0d",
						$time, dist_q[0], m_tdata);
					n_errors++;
				end
				void'(dist_q.pop_front());
				n_dists++;
			end
		end
	end

	// receiver backpressure
	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 14);
	end

	// send one feature pair; model updates on acceptance, valid stays up
	// until the next pair or an idle wait replaces it
	task automatic send_pair(input logic [15:0] fa, input logic [15:0] fb, input logic lst);
		while (!calm && $urandom_range(99) < 14) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {fb, fa};
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
		accumulate(fa, fb, lst);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (dist_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [23:0] val);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_METRIC)
			cur_metric = val[METRIC_W-1:0];
		else
			cur_inv = val;
	endtask

	task automatic test_euclid_directed();
		write_reg(REG_METRIC, METRIC_EUCLID);
		send_pair(16'h0000, 16'h0000, 1'b1);
		send_pair(16'h7FFF, 16'h8000, 1'b1);
		send_pair(16'h8000, 16'h7FFF, 1'b1);
		send_pair(16'h0100, 16'h0000, 1'b0);
		send_pair(16'hFF00, 16'h0000, 1'b0);
		send_pair(16'hFFFF, 16'h0001, 1'b1);
		send_pair(16'h1234, 16'h1234, 1'b1);
	endtask

	task automatic test_kernel_directed();
		write_reg(REG_METRIC, METRIC_KERNEL);
		write_reg(REG_INV, 24'h01_0000);
		send_pair(16'h0000, 16'h0000, 1'b1);
		send_pair(16'h0100, 16'h0000, 1'b1);
		send_pair(16'h0040, 16'hFFC0, 1'b1);
		send_pair(16'h7FFF, 16'h8000, 1'b1);
		write_reg(REG_INV, 24'h00_0000);
		send_pair(16'h7FFF, 16'h8000, 1'b1);
		write_reg(REG_INV, 24'hFF_FFFF);
		send_pair(16'h0001, 16'h0000, 1'b1);
		send_pair(16'h0000, 16'h0000, 1'b1);
		write_reg(REG_INV, 24'h00_0001);
		send_pair(16'h0003, 16'h0000, 1'b1);
	endtask

	task automatic test_unused_metric();
		write_reg(REG_METRIC, 2'd2);
		send_pair(16'h7FFF, 16'h8000, 1'b1);
		write_reg(REG_METRIC, 2'd3);
		send_pair(16'h0055, 16'h00AA, 1'b1);
	endtask

	// accumulator saturation: 260 full-scale differences exceed 2^40
	task automatic test_saturation();
		write_reg(REG_METRIC, METRIC_EUCLID);
		for (int i = 0; i < 260; i++)
			send_pair(16'h7FFF, 16'h8000, i == 259);
		write_reg(REG_METRIC, METRIC_KERNEL);
		for (int i = 0; i < 260; i++)
			send_pair(16'h8000, 16'h7FFF, i == 259);
	endtask

	function automatic logic [15:0] rand_feature(input bit narrow);
		if (narrow)
			return 16'($signed($urandom_range(1023)) - 512);
		return 16'($urandom);
	endfunction

	task automatic test_random();
		int sent;
		int pts;
		int len;
		bit narrow;
		logic [23:0] inv;
		sent = 0;
		pts = 0;
		while (sent < 1450) begin
			// reconfigure now and then, extremes included
			if (pts % 40 == 0) begin
				write_reg(REG_METRIC, ($urandom_range(9) < 8) ? 24'($urandom_range(1))
					: 24'($urandom_range(3)));
				case ($urandom_range(4))
					0: inv = 24'h00_0000;
					1: inv = 24'hFF_FFFF;
					2: inv = 24'h01_0000;
					default: inv = 24'($urandom);
				endcase
				write_reg(REG_INV, inv);
			end
			calm = (pts >= 120 && pts < 180);
			len = ($urandom_range(9) == 0) ? $urandom_range(70, 1) : $urandom_range(8, 1);
			narrow = ($urandom_range(2) != 0);
			for (int i = 0; i < len; i++)
				send_pair(rand_feature(narrow), rand_feature(narrow), i == len - 1);
			sent += len;
			pts++;
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tlast    = 1'b0;
		m_tready   = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		cur_metric = METRIC_EUCLID;
		cur_inv    = 24'h01_0000;
		acc_sum    = 0;
		n_errors   = 0;
		n_items    = 0;
		n_dists    = 0;
		n_kernel   = 0;
		n_sat      = 0;
		calm       = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_euclid_directed();
		test_kernel_directed();
		test_unused_metric();
		test_saturation();
		test_random();
		wait_idle();

		$display("Sent %0d feature pairs, checked %0d distances (%0d kernel).",
			n_items, n_dists, n_kernel);
		$display("Accumulator saturated %0d times; all metrics and inv_sigma_sq extremes used.",
			n_sat);
		if (n_errors == 0 && dist_q.size() == 0) begin
			$display("** point_distance_unit_core: PASSED **");
		end else begin
			$display("** point_distance_unit_core: FAILED **");
		end
		$finish;
	end

endmodule
